[rtl/packed_raw_sample_unpacker_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the packed raw sample unpacker
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKED_RAW_SAMPLE_UNPACKER_ASSERT_SVH
`define PACKED_RAW_SAMPLE_UNPACKER_ASSERT_SVH

// Same-cycle implication
`define PRSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PRSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/prsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsu_pkg
// Shared types and constants of the packed raw sample unpacker.
// ----------------------------------------------------------------------------
package prsu_pkg;

    localparam int WORD_W   = 16;
    localparam int MODE_W   = 2;
    localparam int ACC_W    = 13;
    localparam int HELD_W   = 4;
    localparam int STREAM_W = ACC_W + WORD_W;
    localparam int SHIFT_W  = 5;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Sample width modes; the unused code falls back to passthrough
    localparam logic [MODE_W-1:0] MODE_PACK12 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PACK14 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PASS   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    localparam logic [WORD_W-1:0] MASK12   = 16'h0fff;
    localparam logic [WORD_W-1:0] MASK14   = 16'h3fff;
    localparam logic [WORD_W-1:0] MASK16   = 16'hffff;

    // One decoded request: up to two samples cut from one word
    typedef struct packed {
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
        logic              two;
    } prsu_entry_t;

endpackage

[rtl/prsu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsu_front
// Accepts words, appends them to the bit stream and cuts one or two samples.
// ----------------------------------------------------------------------------
module prsu_front
    import prsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MODE_W-1:0] mode,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [WORD_W-1:0] packed_word,
    input  logic              end_of_strip,
    input  logic              q_full,
    output logic              q_push,
    output prsu_entry_t       q_wdata
);

    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    acc_next;
    logic [HELD_W-1:0]   held_reg;
    logic [HELD_W-1:0]   held_next;
    logic [WORD_W-1:0]   swapped;
    logic [STREAM_W-1:0] stream;
    logic [SHIFT_W-1:0]  held_sum;
    logic [SHIFT_W-1:0]  width;
    logic [WORD_W-1:0]   mask;
    logic                packed_mode;
    logic [SHIFT_W-1:0]  first_rem;
    logic [SHIFT_W-1:0]  second_rem;
    logic [SHIFT_W-1:0]  keep_bits;
    logic [STREAM_W-1:0] first_shift;
    logic [STREAM_W-1:0] second_shift;
    logic [STREAM_W-1:0] keep_mask;
    logic [STREAM_W-1:0] kept;
    logic                two;

    // Stall only on a full queue
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Decode the width and cut the samples from the top of the stream
    always_comb
    begin
        swapped  = {packed_word[7:0], packed_word[15:8]};
        stream   = {acc_reg, swapped};
        held_sum = {1'b0, held_reg} + SHIFT_W'(WORD_W);
        case (mode)
            MODE_PACK12:
            begin
                width       = SHIFT_W'(12);
                mask        = MASK12;
                packed_mode = 1'b1;
            end
            MODE_PACK14:
            begin
                width       = SHIFT_W'(14);
                mask        = MASK14;
                packed_mode = 1'b1;
            end
            default:
            begin
                width       = SHIFT_W'(WORD_W);
                mask        = MASK16;
                packed_mode = 1'b0;
            end
        endcase
        first_rem    = held_sum - width;
        two          = packed_mode && (first_rem >= width);
        second_rem   = first_rem - width;
        first_shift  = stream >> first_rem;
        second_shift = stream >> second_rem;
        keep_bits    = two ? second_rem : first_rem;
        keep_mask    = (STREAM_W'(1) << keep_bits) - STREAM_W'(1);
        kept         = stream & keep_mask;

        q_wdata.first  = packed_mode ? (first_shift[WORD_W-1:0] & mask) : packed_word;
        q_wdata.second = second_shift[WORD_W-1:0] & mask;
        q_wdata.two    = two;

        // Advance the held bits; drop them at the end of a strip
        acc_next  = acc_reg;
        held_next = held_reg;
        if (q_push)
        begin
            if (packed_mode)
            begin
                acc_next  = kept[ACC_W-1:0];
                held_next = keep_bits[HELD_W-1:0];
            end
            if (end_of_strip)
            begin
                acc_next  = '0;
                held_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            held_reg <= held_next;
        end
    end

endmodule

[rtl/prsu_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsu_queue
// Short first-in first-out queue of decoded requests between front and back.
// ----------------------------------------------------------------------------
module prsu_queue
    import prsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  prsu_entry_t wdata,
    input  logic        pop,
    output prsu_entry_t head,
    output logic        full,
    output logic        empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    prsu_entry_t        slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign head  = slots_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/prsu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsu_back
// Emits the queued samples one per cycle, unless out_stall holds it, through an output register.
// ----------------------------------------------------------------------------
module prsu_back
    import prsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  prsu_entry_t       q_head,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] sample_value,
    output logic              last_of_word
);

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] sample_reg;
    logic [WORD_W-1:0] sample_next;
    logic              last_reg;
    logic              last_next;
    logic              load_ok;
    logic              take;
    logic              is_last;

    assign out_valid    = valid_reg;
    assign sample_value = sample_reg;
    assign last_of_word = last_reg;

    // Load the output register when it is empty or being taken
    always_comb
    begin
        load_ok     = !valid_reg || !out_stall;
        take        = load_ok && !q_empty;
        is_last     = (phase_reg == PH_SECOND) || !q_head.two;
        q_pop       = take && is_last;
        phase_next  = phase_reg;
        valid_next  = valid_reg;
        sample_next = sample_reg;
        last_next   = last_reg;
        if (take)
        begin
            valid_next  = 1'b1;
            sample_next = (phase_reg == PH_SECOND) ? q_head.second : q_head.first;
            last_next   = is_last;
            phase_next  = is_last ? PH_FIRST : PH_SECOND;
        end
        else if (load_ok)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            valid_reg  <= 1'b0;
            sample_reg <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            valid_reg  <= valid_next;
            sample_reg <= sample_next;
            last_reg   <= last_next;
        end
    end

endmodule

[rtl/packed_raw_sample_unpacker.sv]
`timescale 1ns / 1ps
// An accepted word passes through the queue slot and then the output register before
// its first sample shows. Words are accepted one per cycle unless the queue is full;
// the output register sends one sample per cycle unless out_stall holds it.
// Reset (rst_n low, asynchronous) empties the queue, drops the held stream bits
// and selects 12-bit packed mode.
// ----------------------------------------------------------------------------
// packed_raw_sample_unpacker
// Unpacks 12/14-bit packed raw samples from byte-swapped 16-bit words, or passes words through unswapped.
// ----------------------------------------------------------------------------
`include "packed_raw_sample_unpacker_assert.svh"

module packed_raw_sample_unpacker
    import prsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [MODE_W-1:0] cfg_write_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [WORD_W-1:0] packed_word,
    input  logic              end_of_strip,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] sample_value,
    output logic              last_of_word
);

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    prsu_entry_t       q_wdata;
    prsu_entry_t       q_head;

    // Hold the sample width mode
    assign mode_next = cfg_write_en ? cfg_write_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PACK12;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    prsu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .packed_word  (packed_word),
        .end_of_strip (end_of_strip),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    prsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .head  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    prsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value),
        .last_of_word (last_of_word)
    );

    // Checks
    `PRSU_ASSERT_SAME(a_full_stalls, q_full, in_stall && !q_push, "request accepted into full queue")
    `PRSU_ASSERT_SAME(a_pop_nonempty, q_pop, !q_empty, "pop from empty queue")
    `PRSU_ASSERT_SAME(a_pass_last, out_valid && mode_reg[1], last_of_word, "passthrough sample not last")
    `PRSU_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_empty, "queue empty after push")

endmodule

[test/packed_raw_sample_unpacker_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_raw_sample_unpacker_test
// Self-checking bench for the packed raw sample unpacker. Byte-swapped words
// are fed in 12-bit, 14-bit, passthrough and the spare mode. The bench keeps
// its own bit-stream copy to predict every sample and its last-of-word mark.
// Output samples are checked in order against those predictions, with random
// idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module packed_raw_sample_unpacker_test;
    import prsu_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 80;
    localparam int IDLE_LIMIT    = 2000;
    localparam int BLOCK_WORDS   = 42;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              eos;
    } word_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last;
    } sample_t;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_write_en   = 1'b0;
    logic [MODE_W-1:0] cfg_write_data = MODE_PACK12;
    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic [WORD_W-1:0] packed_word    = '0;
    logic              end_of_strip   = 1'b0;
    logic              out_valid;
    logic              out_stall      = 1'b0;
    logic [WORD_W-1:0] sample_value;
    logic              last_of_word;

    // Bench copy of the block state and mode
    logic [MODE_W-1:0] width_mode  = MODE_PACK12;
    logic [28:0]       stream_bits = '0;
    logic [4:0]        stream_held = '0;

    word_req_t word_queue[$];
    sample_t   sample_queue[$];

    int send_idle_pct  = 17;
    int recv_stall_pct = 80;
    int bursts_asked   = 0;
    int bursts_served  = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int words_sent     = 0;
    int samples_seen   = 0;
    int strips_closed  = 0;
    int mode_writes    = 0;
    int error_count    = 0;

    packed_raw_sample_unpacker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .packed_word    (packed_word),
        .end_of_strip   (end_of_strip),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample_value   (sample_value),
        .last_of_word   (last_of_word)
    );

    // Clock
    initial
    begin
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    // Cut the samples one word yields and advance the bench stream state
    function automatic void unpack_word(input logic [WORD_W-1:0] word, input logic eos);
        logic [44:0]       stream;
        logic [44:0]       shifted;
        logic [5:0]        held;
        logic [5:0]        width;
        logic [WORD_W-1:0] mask;
        sample_t           cut[2];
        int                n;
        n = 0;
        if (width_mode == MODE_PACK12 || width_mode == MODE_PACK14)
        begin
            width  = (width_mode == MODE_PACK12) ? 6'd12 : 6'd14;
            mask   = (width_mode == MODE_PACK12) ? MASK12 : MASK14;
            stream = {stream_bits, word[7:0], word[15:8]};
            held   = {1'b0, stream_held} + 6'd16;
            while (held >= width && n < 2)
            begin
                held       = held - width;
                shifted    = stream >> held;
                cut[n]     = '0;
                cut[n].value = shifted[WORD_W-1:0] & mask;
                n++;
            end
            for (int i = 0; i < n; i++)
            begin
                cut[i].last = (i == n - 1);
                sample_queue.push_back(cut[i]);
            end
            stream      = stream & ((45'd1 << held) - 45'd1);
            stream_bits = stream[28:0];
            stream_held = held[4:0];
        end
        else
        begin
            // Passthrough and the spare mode: word as is, no swap
            cut[0].value = word;
            cut[0].last  = 1'b1;
            sample_queue.push_back(cut[0]);
        end
        // Drop the leftover partial bits at end of strip
        if (eos)
        begin
            stream_bits = '0;
            stream_held = '0;
        end
    endfunction

    task automatic report_fault(input string what, input sample_t want, input sample_t got);
        if (error_count < REPORT_MAX)
            $display("[%0t] %s: expected value %h last %b, got value %h last %b",
                     $realtime, what, want.value, want.last, got.value, got.last);
        error_count++;
    endtask

    // Request driver: offer queued words, hold while stalled, predict on accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            packed_word  <= '0;
            end_of_strip <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                unpack_word(packed_word, end_of_strip);
                words_sent++;
                if (end_of_strip)
                    strips_closed++;
            end
            if (!in_valid || !in_stall)
            begin
                if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    word_req_t req;
                    req = word_queue.pop_front();
                    in_valid     <= 1'b1;
                    packed_word  <= req.word;
                    end_of_strip <= req.eos;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, or a long hold-off when one is asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (bursts_served != bursts_asked)
        begin
            bursts_served <= bursts_asked;
            hold_left     <= LONG_HOLD;
            out_stall     <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Sample monitor: compare each accepted sample with the oldest prediction
    always @(posedge clk)
    begin
        sample_t got;
        sample_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.value = sample_value;
            got.last  = last_of_word;
            samples_seen++;
            if (sample_queue.size() == 0)
                report_fault("sample with none predicted", '0, got);
            else
            begin
                want = sample_queue.pop_front();
                if (got.value !== want.value || got.last !== want.last)
                    report_fault("sample mismatch", want, got);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no request or sample moved for %0d cycles", IDLE_LIMIT);
                $display("packed_raw_sample_unpacker verification failed");
                $finish;
            end
        end
    end

    task automatic queue_word(input logic [WORD_W-1:0] word, input logic eos);
        word_req_t req;
        req.word = word;
        req.eos  = eos;
        word_queue.push_back(req);
    endtask

    // Wait until every request is taken and every sample has come back
    task automatic wait_idle();
        @(negedge clk);
        while (word_queue.size() != 0 || in_valid || sample_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        wait_idle();
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= mode;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        width_mode = mode;
        mode_writes++;
    endtask

    // Strips of random length and content; some end without the flag
    task automatic queue_strips(input int count);
        int                left;
        int                len;
        logic [WORD_W-1:0] word;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(1, 12);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(9))
                    0:       word = 16'h0000;
                    1:       word = 16'hffff;
                    default: word = 16'($urandom);
                endcase
                queue_word(word, (i == len - 1) && ($urandom_range(7) != 0));
            end
            left -= len;
        end
    endtask

    // Stimulus sequence
    initial
    begin
        logic [MODE_W-1:0] mode;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, strip end, mode change with held bits, spare mode
        write_mode(MODE_PACK12);
        queue_word(16'h0000, 1'b0);
        queue_word(16'hffff, 1'b0);
        queue_word(16'h3412, 1'b0);
        queue_word(16'h7856, 1'b0);
        queue_word(16'ha55a, 1'b1);
        queue_word(16'h0ff0, 1'b0);
        queue_word(16'h1357, 1'b0);
        write_mode(MODE_PACK14);
        queue_word(16'hffff, 1'b0);
        queue_word(16'h0000, 1'b0);
        queue_word(16'h8001, 1'b0);
        queue_word(16'h5aa5, 1'b0);
        write_mode(MODE_PASS);
        queue_word(16'h1234, 1'b0);
        queue_word(16'hffff, 1'b0);
        write_mode(MODE_PACK14);
        queue_word(16'hc3c3, 1'b1);
        write_mode(MODE_SPARE);
        queue_word(16'hbeef, 1'b0);
        queue_word(16'h00ff, 1'b1);
        write_mode(MODE_PACK12);
        queue_word(16'hff00, 1'b1);
        queue_word(16'h0001, 1'b0);
        queue_word(16'h8000, 1'b0);

        // Random: three idling patterns, four mode blocks each
        for (int phase = 0; phase < 3; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 80;
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 17;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++)
            begin
                if (blk < 3)
                    mode = MODE_W'((blk + phase) % 3);
                else
                    mode = MODE_W'($urandom_range(3));
                write_mode(mode);
                queue_strips(BLOCK_WORDS);
                // Hold off the output while words keep coming, to fill the block
                if (phase == 2 && blk == 0)
                    bursts_asked++;
            end
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (sample_queue.size() != 0)
        begin
            $display("%0d predicted samples never arrived", sample_queue.size());
            error_count++;
        end
        $display("Covered %0d words in %0d closed strips, %0d samples, %0d mode writes",
                 words_sent, strips_closed, samples_seen, mode_writes);
        $display("under sender-heavy, receiver-heavy and no-idle traffic; %0d errors",
                 error_count);
        if (error_count == 0)
            $display("packed_raw_sample_unpacker verification clean");
        else
            $display("packed_raw_sample_unpacker verification failed");
        $finish;
    end

endmodule
